// File: rtl/b32d_pkg.sv
package b32d_pkg;

  localparam int unsigned GroupChars = 8;
  localparam int unsigned GroupBytes = 5;
  localparam int unsigned SymBits    = 5;
  localparam int unsigned GroupBits  = GroupChars * SymBits;

  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharTwo    = 8'h32;
  localparam logic [7:0] CharSeven  = 8'h37;
  localparam logic [7:0] CharPad    = 8'h3D;

  // Value of the first digit symbol in the alphabet.
  localparam logic [SymBits-1:0] DigitBase = 5'd26;

  typedef logic [7:0]                       byte_t;
  typedef logic [SymBits-1:0]               sym_t;
  typedef logic [$clog2(GroupChars)-1:0]    count_t;
  typedef logic [$clog2(GroupBytes+1)-1:0]  nbytes_t;
  typedef logic [GroupBits-1:0]             group_t;

  typedef struct packed {
    logic valid;
    logic is_pad;
    sym_t value;
  } decode_t;

  function automatic decode_t char_decode(byte_t c);
    decode_t d;
    byte_t   diff;
    d    = '0;
    diff = '0;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      diff    = c - CharUpperA;
      d.valid = 1'b1;
      d.value = diff[SymBits-1:0];
    end else if (c >= CharTwo && c <= CharSeven) begin
      diff    = c - CharTwo;
      d.valid = 1'b1;
      d.value = diff[SymBits-1:0] + DigitBase;
    end else if (c == CharPad) begin
      d.valid  = 1'b1;
      d.is_pad = 1'b1;
    end
    return d;
  endfunction

endpackage

// File: rtl/b32d_char_if.sv
interface b32d_char_if;
  logic               valid;
  logic               ready;
  b32d_pkg::byte_t    in_char;

  modport source (output valid, output in_char, input ready);
  modport sink   (input valid, input in_char, output ready);
endinterface

// File: rtl/b32d_byte_if.sv
interface b32d_byte_if;
  logic               valid;
  logic               ready;
  b32d_pkg::byte_t    out_byte;
  logic               group_last;

  modport source (output valid, output out_byte, output group_last, input ready);
  modport sink   (input valid, input out_byte, input group_last, output ready);
endinterface

// File: rtl/base32_stream_decoder.sv
// Streaming base32 decoder (standard upper-case alphabet with '=' padding).
// char_i takes one raw text byte per transaction. Bytes outside A-Z, 2-7
// and '=' are dropped. Every eighth valid character closes a group of
// 40 bits, which is handed to an output buffer and sent on byte_o as one
// to five transactions, most significant byte first, with group_last set
// on the final one. The byte count follows the padding in the group.
// The input takes one character per cycle while char_i.ready is high, and
// the output buffer sends one byte per cycle while byte_o.ready is high.
// The first byte of a group is valid on the cycle after the closing
// character is taken.
// While fewer than seven characters are held, bytes are taken even while
// the buffer is draining or stalled; once seven are held, any byte waits
// (ready low) while buffer bytes remain that will not all leave in that cycle.
// Reset clears the partial group, padding marks and the output byte count.
// An unfinished group is never sent; it stays held until completed.
module base32_stream_decoder (
  input  logic clk_i,
  input  logic rst_ni,
  b32d_char_if.sink   char_i,
  b32d_byte_if.source byte_o
);
  import b32d_pkg::*;

  decode_t  dec;
  logic     in_fire;
  logic     out_fire;
  logic     closing;
  logic     buf_free;
  group_t   group_q, group_d;
  count_t   count_q;
  byte_t    pad_q, pad_d;
  group_t   obuf_q;
  nbytes_t  remain_q;
  nbytes_t  nbytes;

  assign dec      = char_decode(char_i.in_char);
  assign in_fire  = char_i.valid && char_i.ready;
  assign out_fire = byte_o.valid && byte_o.ready;

  assign group_d = {group_q[GroupBits-SymBits-1:0], dec.value};
  assign pad_d   = pad_q | (dec.is_pad ? (byte_t'(1) << count_q) : '0);

  assign buf_free     = (remain_q == '0) || (out_fire && remain_q == nbytes_t'(1));
  assign char_i.ready = buf_free || (count_q != count_t'(GroupChars - 1));
  assign closing      = in_fire && dec.valid && (count_q == count_t'(GroupChars - 1));

  always_comb begin
    priority if (pad_d[2]) begin
      nbytes = nbytes_t'(1);
    end else if (pad_d[4]) begin
      nbytes = nbytes_t'(2);
    end else if (pad_d[5]) begin
      nbytes = nbytes_t'(3);
    end else if (pad_d[7]) begin
      nbytes = nbytes_t'(4);
    end else begin
      nbytes = nbytes_t'(GroupBytes);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q <= '0;
      count_q <= '0;
      pad_q   <= '0;
    end else if (in_fire && dec.valid) begin
      if (closing) begin
        group_q <= '0;
        count_q <= '0;
        pad_q   <= '0;
      end else begin
        group_q <= group_d;
        count_q <= count_q + count_t'(1);
        pad_q   <= pad_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q <= '0;
    end else if (closing) begin
      remain_q <= nbytes;
    end else if (out_fire) begin
      remain_q <= remain_q - nbytes_t'(1);
    end
  end

  // Payload only; the byte count alone says whether the buffer holds data.
  always_ff @(posedge clk_i) begin
    if (closing) begin
      obuf_q <= group_d;
    end else if (out_fire) begin
      obuf_q <= {obuf_q[GroupBits-9:0], 8'h00};
    end
  end

  assign byte_o.valid      = (remain_q != '0);
  assign byte_o.out_byte   = obuf_q[GroupBits-1 -: 8];
  assign byte_o.group_last = (remain_q == nbytes_t'(1));

endmodule
